// File: hdl/assert_macros.svh
// Assertion macros used by the datapath of the state-of-charge tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hdl/csoc_pkg.sv
// Shared types and constants of the coulomb-counting state-of-charge tracker.
package csoc_pkg;

    localparam int CUR_W   = 24;
    localparam int MV_W    = 16;
    localparam int CAP_W   = 23;
    localparam int SOC_W   = 10;
    localparam int PCT_W   = 7;
    localparam int CYC_W   = 16;
    localparam int HOLD_W  = 16;

    localparam int IN_W    = CUR_W + 3 * MV_W;
    localparam int OUT_W   = 40;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    // Charge is kept in mA*ms.
    localparam int PERIOD_MS = 1000;
    localparam int PERIOD_W  = $clog2(PERIOD_MS + 1) + 1;
    localparam logic signed [PERIOD_W-1:0] PERIOD_S = PERIOD_W'(PERIOD_MS);
    localparam int PROD_W    = CUR_W + PERIOD_W;

    localparam int STEP_MULT_W = 12;
    localparam logic [STEP_MULT_W-1:0] STEP_MULT = STEP_MULT_W'(3600);
    localparam int STEP_W      = CAP_W + STEP_MULT_W;

    localparam int REM_W     = 40;
    localparam int DIV_BITS  = REM_W;
    localparam int DIV_CNT_W = $clog2(DIV_BITS);

    localparam logic [SOC_W-1:0] SOC_MAX = SOC_W'(1000);
    localparam logic [CUR_W-1:0] FULL_CUR_LIMIT = CUR_W'(100);
    localparam logic [MV_W-1:0]  FULL_AVG_MIN = MV_W'(3400);
    localparam logic [MV_W-1:0]  FULL_MARGIN  = MV_W'(50);
    localparam logic [MV_W-1:0]  FULL_MV_DEF  = MV_W'(3500);
    localparam logic [MV_W-1:0]  EMPTY_MV_DEF = MV_W'(3000);
    localparam logic [MV_W-1:0]  AVG_VALID_MIN = MV_W'(2000);
    localparam logic [MV_W-1:0]  AVG_VALID_MAX = MV_W'(5000);
    localparam logic [MV_W-1:0]  EMPTY_AVG    = MV_W'(3000);
    localparam logic [MV_W-1:0]  MV_UNSET     = MV_W'(16'hFFFF);
    localparam logic [HOLD_W-1:0] HOLD_SAT    = HOLD_W'(16'hFFFF);

    // (x + 5) / 10 for x up to 1000 as a multiply by 205 and shift by 11.
    localparam logic [7:0] PCT_RECIP = 8'd205;
    localparam int         PCT_SHIFT = 11;
    localparam logic [SOC_W:0] PCT_ROUND = (SOC_W + 1)'(5);

    localparam logic [CAP_W-1:0]  CAP_RST      = CAP_W'(50000);
    localparam logic [MV_W-1:0]   IDLE_RST     = MV_W'(100);
    localparam logic [MV_W-1:0]   FULL_MV_RST  = MV_W'(3500);
    localparam logic [MV_W-1:0]   EMPTY_MV_RST = MV_W'(3000);
    localparam logic [HOLD_W-1:0] HOLD_RST     = HOLD_W'(300);
    localparam logic [SOC_W-1:0]  SOC_RST      = SOC_W'(500);
    localparam logic [CYC_W-1:0]  CYC_RST      = CYC_W'(0);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY  = 3'd0,
        CFG_IDLE      = 3'd1,
        CFG_FULL_MV   = 3'd2,
        CFG_EMPTY_MV  = 3'd3,
        CFG_HOLD      = 3'd4,
        CFG_START_SOC = 3'd5,
        CFG_START_CYC = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_PREP,
        ST_DIV,
        ST_UPD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic mult;
        logic prep;
        logic div_step;
        logic update;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

// File: hdl/csoc_ctrl.sv
// Sequencing state machine of the state-of-charge tracker.
module csoc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  csoc_pkg::dp_stat_t    stat,
    output csoc_pkg::ctrl_cmd_t   cmd
);

    csoc_pkg::state_t state_reg, state_next;
    logic [csoc_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= csoc_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            csoc_pkg::ST_IDLE: begin
                // No word is taken while reset is held.
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.load_in = 1'b1;
                    state_next  = csoc_pkg::ST_PROD;
                end
            end
            csoc_pkg::ST_PROD: begin
                cmd.mult   = 1'b1;
                state_next = csoc_pkg::ST_PREP;
            end
            csoc_pkg::ST_PREP: begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = csoc_pkg::ST_DIV;
            end
            csoc_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + csoc_pkg::DIV_CNT_W'(1);
                if (cnt_reg == csoc_pkg::DIV_CNT_W'(csoc_pkg::DIV_BITS - 1)) begin
                    state_next = csoc_pkg::ST_UPD;
                end
            end
            csoc_pkg::ST_UPD: begin
                cmd.update = 1'b1;
                state_next = csoc_pkg::ST_OUT;
            end
            csoc_pkg::ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = csoc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = csoc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/csoc_dp.sv
// Datapath of the state-of-charge tracker: settings, charge integration, calibration, output.
`include "assert_macros.svh"

module csoc_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [csoc_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [csoc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [csoc_pkg::IN_W-1:0]         s_tdata,
    input  csoc_pkg::ctrl_cmd_t               cmd,
    output csoc_pkg::dp_stat_t                stat,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [csoc_pkg::OUT_W-1:0]        m_tdata
);

    localparam int CW = csoc_pkg::CUR_W;
    localparam int VW = csoc_pkg::MV_W;
    localparam int SW = csoc_pkg::SOC_W;
    localparam int RW = csoc_pkg::REM_W;
    localparam int TW = csoc_pkg::STEP_W;
    localparam int PCT_W_HI = csoc_pkg::PCT_SHIFT + csoc_pkg::PCT_W - 1;

    // Settings.
    logic [csoc_pkg::CAP_W-1:0]  cap_reg;
    logic [VW-1:0]               idle_reg, full_mv_reg, empty_mv_reg;
    logic [csoc_pkg::HOLD_W-1:0] hold_per_reg;

    // Captured word.
    logic signed [CW-1:0] cur_reg;
    logic [VW-1:0]        avg_reg, max_reg, min_reg;

    // Integration and division.
    logic signed [csoc_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [TW-1:0]  step_reg, step_next;
    logic           skip_reg, skip_next;
    logic           sign_reg, sign_next;
    logic [RW-1:0]  dq_reg, dq_next;
    logic [TW-1:0]  dr_reg, dr_next;

    // Tracker state.
    logic [SW-1:0]               soc_reg, soc_next;
    logic signed [RW-1:0]        rem_reg, rem_next;
    logic                        det_reg, det_next;
    logic [csoc_pkg::HOLD_W-1:0] hold_reg, hold_next;
    logic [csoc_pkg::CYC_W-1:0]  cyc_reg, cyc_next;
    logic                        full_ev_reg, full_ev_next;
    logic                        empty_ev_reg, empty_ev_next;

    // Output register.
    logic                        m_valid_reg, m_valid_next;
    logic [SW-1:0]               m_soc_reg;
    logic [csoc_pkg::PCT_W-1:0]  m_pct_reg;
    logic [csoc_pkg::CYC_W-1:0]  m_cyc_reg;
    logic                        m_full_reg, m_empty_reg;

    logic [CW-1:0]        mag;
    logic signed [RW-1:0] sum;
    logic [TW:0]          trial;
    logic                 trial_ge;
    logic [SW-1:0]        soc_int;
    logic signed [RW-1:0] rem_int;
    logic [SW-1:0]        soc_room;
    logic [VW-1:0]        full_mv, empty_mv, full_thr;
    logic                 avg_ok, full_cond;
    logic [csoc_pkg::HOLD_W-1:0] hold_inc;
    logic [SW:0]          pct_in;
    logic [SW+8:0]        pct_prod;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg      <= csoc_pkg::CAP_RST;
            idle_reg     <= csoc_pkg::IDLE_RST;
            full_mv_reg  <= csoc_pkg::FULL_MV_RST;
            empty_mv_reg <= csoc_pkg::EMPTY_MV_RST;
            hold_per_reg <= csoc_pkg::HOLD_RST;
        end else if (cfg_wr_en) begin
            case (csoc_pkg::cfg_idx_t'(cfg_addr))
                csoc_pkg::CFG_CAPACITY: cap_reg      <= cfg_wdata;
                csoc_pkg::CFG_IDLE:     idle_reg     <= VW'(cfg_wdata);
                csoc_pkg::CFG_FULL_MV:  full_mv_reg  <= VW'(cfg_wdata);
                csoc_pkg::CFG_EMPTY_MV: empty_mv_reg <= VW'(cfg_wdata);
                csoc_pkg::CFG_HOLD:     hold_per_reg <= csoc_pkg::HOLD_W'(cfg_wdata);
                // The start values only matter at reset, where their reset values apply.
                csoc_pkg::CFG_START_SOC: begin
                end
                csoc_pkg::CFG_START_CYC: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cur_reg <= s_tdata[CW-1:0];
            avg_reg <= s_tdata[CW+VW-1:CW];
            max_reg <= s_tdata[CW+2*VW-1:CW+VW];
            min_reg <= s_tdata[CW+3*VW-1:CW+2*VW];
        end
        prod_reg     <= prod_next;
        step_reg     <= step_next;
        skip_reg     <= skip_next;
        sign_reg     <= sign_next;
        dq_reg       <= dq_next;
        dr_reg       <= dr_next;
        full_ev_reg  <= full_ev_next;
        empty_ev_reg <= empty_ev_next;
        if (cmd.out_load) begin
            m_soc_reg   <= soc_reg;
            m_pct_reg   <= pct_prod[PCT_W_HI:csoc_pkg::PCT_SHIFT];
            m_cyc_reg   <= cyc_reg;
            m_full_reg  <= full_ev_reg;
            m_empty_reg <= empty_ev_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            soc_reg     <= csoc_pkg::SOC_RST;
            rem_reg     <= '0;
            det_reg     <= 1'b0;
            hold_reg    <= '0;
            cyc_reg     <= csoc_pkg::CYC_RST;
            m_valid_reg <= 1'b0;
        end else begin
            soc_reg     <= soc_next;
            rem_reg     <= rem_next;
            det_reg     <= det_next;
            hold_reg    <= hold_next;
            cyc_reg     <= cyc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign mag = cur_reg[CW-1] ? CW'(-cur_reg) : CW'(cur_reg);
    assign sum = rem_reg + RW'(prod_reg);

    // One restoring division step: shift in a dividend bit, subtract when it fits.
    assign trial    = {dr_reg, dq_reg[RW-1]};
    assign trial_ge = trial >= {1'b0, step_reg};

    assign pct_in   = {1'b0, soc_reg} + csoc_pkg::PCT_ROUND;
    assign pct_prod = (SW + 9)'(pct_in) * (SW + 9)'(csoc_pkg::PCT_RECIP);

    always_comb begin
        prod_next = prod_reg;
        step_next = step_reg;
        skip_next = skip_reg;
        sign_next = sign_reg;
        dq_next   = dq_reg;
        dr_next   = dr_reg;
        if (cmd.mult) begin
            prod_next = csoc_pkg::PROD_W'(cur_reg) * csoc_pkg::PROD_W'(csoc_pkg::PERIOD_S);
            step_next = TW'(cap_reg) * TW'(csoc_pkg::STEP_MULT);
            skip_next = (mag < CW'(idle_reg)) || (cap_reg == '0);
        end
        if (cmd.prep) begin
            sign_next = sum[RW-1];
            dq_next   = sum[RW-1] ? RW'(-sum) : RW'(sum);
            dr_next   = '0;
        end
        if (cmd.div_step) begin
            dr_next = trial_ge ? TW'(trial - {1'b0, step_reg}) : TW'(trial);
            dq_next = {dq_reg[RW-2:0], trial_ge};
        end
    end

    // Integration result: unless the step is skipped, quotient moves the SOC, remainder keeps the dividend's sign.
    always_comb begin
        soc_room = csoc_pkg::SOC_MAX - soc_reg;
        if (skip_reg) begin
            soc_int = soc_reg;
            rem_int = rem_reg;
        end else if (sign_reg) begin
            rem_int = -(RW'(dr_reg));
            soc_int = (dq_reg >= RW'(soc_reg)) ? '0 : soc_reg - dq_reg[SW-1:0];
        end else begin
            rem_int = RW'(dr_reg);
            soc_int = (dq_reg > RW'(soc_room)) ? csoc_pkg::SOC_MAX
                                               : soc_reg + dq_reg[SW-1:0];
        end
    end

    always_comb begin
        full_mv  = (full_mv_reg == '0 || full_mv_reg == csoc_pkg::MV_UNSET)
                   ? csoc_pkg::FULL_MV_DEF : full_mv_reg;
        empty_mv = (empty_mv_reg == '0 || empty_mv_reg == csoc_pkg::MV_UNSET)
                   ? csoc_pkg::EMPTY_MV_DEF : empty_mv_reg;
        full_thr = full_mv - csoc_pkg::FULL_MARGIN;
        avg_ok   = (avg_reg >= csoc_pkg::AVG_VALID_MIN) && (avg_reg <= csoc_pkg::AVG_VALID_MAX);
        full_cond = (mag < csoc_pkg::FULL_CUR_LIMIT) && (avg_reg >= csoc_pkg::FULL_AVG_MIN)
                    && (max_reg >= full_thr);
        hold_inc = (hold_reg == csoc_pkg::HOLD_SAT) ? hold_reg
                                                    : hold_reg + csoc_pkg::HOLD_W'(1);

        soc_next      = soc_reg;
        rem_next      = rem_reg;
        det_next      = det_reg;
        hold_next     = hold_reg;
        cyc_next      = cyc_reg;
        full_ev_next  = full_ev_reg;
        empty_ev_next = empty_ev_reg;

        if (cmd.update) begin
            soc_next      = soc_int;
            rem_next      = rem_int;
            full_ev_next  = 1'b0;
            empty_ev_next = 1'b0;
            if (!avg_ok) begin
                det_next = 1'b0;
            end else begin
                if (full_cond) begin
                    if (!det_reg) begin
                        det_next  = 1'b1;
                        hold_next = '0;
                    end else begin
                        hold_next = hold_inc;
                        if (hold_inc >= hold_per_reg) begin
                            soc_next     = csoc_pkg::SOC_MAX;
                            rem_next     = '0;
                            cyc_next     = cyc_reg + csoc_pkg::CYC_W'(1);
                            det_next     = 1'b0;
                            full_ev_next = 1'b1;
                        end
                    end
                end else begin
                    det_next = 1'b0;
                end
                // Empty runs after full, so an empty pack in the same period ends at zero.
                if (avg_reg < csoc_pkg::EMPTY_AVG || min_reg <= empty_mv) begin
                    soc_next      = '0;
                    rem_next      = '0;
                    empty_ev_next = 1'b1;
                end
            end
        end
    end

    always_comb begin
        stat.out_free = !m_valid_reg || m_tready;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(csoc_pkg::OUT_W - SW - csoc_pkg::PCT_W - csoc_pkg::CYC_W - 2){1'b0}},
                       m_empty_reg, m_full_reg, m_cyc_reg, m_pct_reg, m_soc_reg};

    `ASSERT_ALWAYS(a_soc_range, soc_reg <= csoc_pkg::SOC_MAX, "SOC left its range")
    `ASSERT_IMPL(a_empty_soc, m_valid_reg && m_empty_reg, m_soc_reg == '0,
        "empty event with nonzero SOC")
    `ASSERT_IMPL(a_full_soc, m_valid_reg && m_full_reg && !m_empty_reg,
        m_soc_reg == csoc_pkg::SOC_MAX, "full event without full SOC")

endmodule

// File: hdl/coulomb_soc_tracker.sv
// Top level of the coulomb-counting state-of-charge tracker.
//
// Usage: one input word per update period on the s_ stream carries the pack
// current and cell voltages; each accepted word yields exactly one result
// word on the m_ stream with the updated SOC, rounded percent, cycle count
// and the full and empty calibration flags.
// Settings are written through cfg_wr_en, cfg_addr and cfg_wdata while the
// block is idle; they take effect with the next input word.
// After a word is accepted it passes through the product, preparation,
// division, update and output states; the charge step is found there by a
// bit-serial divider of 40 iterations. No new word is taken until the
// result is loaded into the output register: s_tready is high only between words.
// When the receiver stalls, the finished result waits in the output
// register; the next input word is still accepted and processed, and its
// result waits until the register is taken.
// Reset (aresetn low, synchronous) restores all settings to their defaults,
// the SOC to 50.0 %, the cycle count to zero and clears the charge
// remainder and any pending result.
module coulomb_soc_tracker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [csoc_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [csoc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // current_ma[23:0], mean_mv[39:24], max_cell_mv[55:40], min_cell_mv[71:56]
    input  logic [csoc_pkg::IN_W-1:0]         s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // soc_tenth_pct[9:0], soc_whole_pct[16:10], cycle_count[32:17],
    // full_event[33], empty_event[34], zero[39:35]
    output logic [csoc_pkg::OUT_W-1:0]        m_tdata
);

    csoc_pkg::ctrl_cmd_t cmd;
    csoc_pkg::dp_stat_t  stat;

    csoc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    csoc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: test/tb_coulomb_soc_tracker.sv
// Self-checking testbench for the coulomb-counting state-of-charge tracker.
module tb_coulomb_soc_tracker;

    // Behavior constants of the tracker, kept apart from the RTL package.
    localparam int    UPDATE_MS      = 1000;
    localparam longint MAS_PER_MAH   = 3600;
    localparam int    SOC_FULL       = 1000;
    localparam int    FULL_IDLE_MA   = 100;
    localparam int    FULL_AVG_MV    = 3400;
    localparam int    FULL_MARGIN_MV = 50;
    localparam int    DEF_FULL_MV    = 3500;
    localparam int    DEF_EMPTY_MV   = 3000;
    localparam int    AVG_MIN_MV     = 2000;
    localparam int    AVG_MAX_MV     = 5000;
    localparam int    EMPTY_AVG_MV   = 3000;
    localparam int    UNSET_MV       = 16'hFFFF;
    localparam int    HOLD_SATURATE  = 16'hFFFF;

    localparam int CAP_DEF       = 50000;
    localparam int IDLE_DEF      = 100;
    localparam int FULL_MV_DEF_R = 3500;
    localparam int EMPTY_MV_DEF_R = 3000;
    localparam int HOLD_DEF      = 300;
    localparam int START_SOC_DEF = 500;
    localparam int START_CYC_DEF = 0;

    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 60;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct packed {
        logic [15:0] vmin;
        logic [15:0] vmax;
        logic [15:0] avg;
        logic [23:0] cur;
    } reading_t;

    typedef struct packed {
        logic [4:0]  pad;
        logic        empty_ev;
        logic        full_ev;
        logic [15:0] cycles;
        logic [6:0]  pct;
        logic [9:0]  soc;
    } soc_result_t;

    typedef enum {RK_DRIFT, RK_FULL, RK_EMPTY, RK_BADV, RK_NOISE} reading_kind_t;
    typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_STARVED} stall_mode_t;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [csoc_pkg::CFG_IDX_W-1:0]  cfg_addr;
    logic [csoc_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                            s_tvalid;
    logic                            s_tready;
    // current_ma[23:0], mean_mv[39:24], max_cell_mv[55:40], min_cell_mv[71:56]
    logic [csoc_pkg::IN_W-1:0]       s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    // soc_tenth_pct[9:0], soc_whole_pct[16:10], cycle_count[32:17],
    // full_event[33], empty_event[34], zero[39:35]
    logic [csoc_pkg::OUT_W-1:0]      m_tdata;

    // Predictor settings and state.
    logic [22:0] cap_mah;
    logic [15:0] idle_ma;
    logic [15:0] full_mv;
    logic [15:0] empty_mv;
    logic [15:0] hold_need;
    logic [9:0]  start_soc;
    logic [15:0] start_cyc;
    logic [9:0]  soc_now;
    longint      charge_rem;
    bit          full_seen;
    logic [15:0] hold_cnt;
    logic [15:0] cycle_cnt;

    soc_result_t pending_soc[$];
    int          error_count = 0;
    int          elapsed_cycles = 0;
    int          burst_left = 0;

    coulomb_soc_tracker DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [15:0] full_thr();
        int fv;
        fv = (full_mv == 0 || full_mv == UNSET_MV) ? DEF_FULL_MV : int'(full_mv);
        // A full voltage below the margin wraps to a very high threshold.
        return 16'(fv - FULL_MARGIN_MV);
    endfunction

    function automatic logic [15:0] empty_floor();
        return (empty_mv == 0 || empty_mv == UNSET_MV) ? 16'(DEF_EMPTY_MV) : empty_mv;
    endfunction

    function automatic soc_result_t advance_soc(input reading_t r);
        soc_result_t res;
        longint      cur;
        longint      mag;
        longint      step_charge;
        longint      q;
        longint      nxt;
        bit          cond;
        cur = longint'($signed(r.cur));
        mag = (cur < 0) ? -cur : cur;
        res = '0;
        if (mag >= longint'(idle_ma) && cap_mah != 0) begin
            charge_rem += cur * UPDATE_MS;
            step_charge = longint'(cap_mah) * MAS_PER_MAH;
            q = charge_rem / step_charge;
            charge_rem = charge_rem % step_charge;
            if (q != 0) begin
                nxt = longint'(soc_now) + q;
                if (nxt < 0) nxt = 0;
                if (nxt > SOC_FULL) nxt = SOC_FULL;
                soc_now = 10'(nxt);
            end
        end
        if (r.avg < AVG_MIN_MV || r.avg > AVG_MAX_MV) begin
            full_seen = 1'b0;
        end else begin
            cond = mag < FULL_IDLE_MA && r.avg >= FULL_AVG_MV && r.vmax >= full_thr();
            if (!cond) begin
                full_seen = 1'b0;
            end else if (!full_seen) begin
                full_seen = 1'b1;
                hold_cnt = '0;
            end else begin
                if (hold_cnt != HOLD_SATURATE) hold_cnt++;
                if (hold_cnt >= hold_need) begin
                    soc_now = 10'(SOC_FULL);
                    charge_rem = 0;
                    cycle_cnt++;
                    full_seen = 1'b0;
                    res.full_ev = 1'b1;
                end
            end
            if (r.avg < EMPTY_AVG_MV || r.vmin <= empty_floor()) begin
                soc_now = '0;
                charge_rem = 0;
                res.empty_ev = 1'b1;
            end
        end
        res.soc = soc_now;
        res.pct = 7'((int'(soc_now) + 5) / 10);
        res.cycles = cycle_cnt;
        return res;
    endfunction

    function automatic reading_t pack_reading(input int cur, input int avg, input int vmax,
                                              input int vmin);
        reading_t r;
        r.cur = 24'(cur);
        r.avg = 16'(avg);
        r.vmax = 16'(vmax);
        r.vmin = 16'(vmin);
        return r;
    endfunction

    function automatic reading_t make_reading(input reading_kind_t kind);
        reading_t r;
        int       thr;
        int       ev;
        int       cur;
        thr = int'(full_thr());
        ev = int'(empty_floor());
        r = pack_reading(int'($urandom), int'($urandom), int'($urandom), int'($urandom));
        case ($urandom_range(0, 3))
            0: cur = int'($urandom_range(0, 600)) - 300;
            1: cur = int'($urandom_range(0, 40000)) - 20000;
            2: cur = int'($urandom_range(0, 13107000)) - 6553500;
            default: cur = int'($urandom);
        endcase
        // Most readings stay clear of the empty floor so the SOC can drift.
        if ($urandom_range(0, 7) != 0 && ev < 65535)
            r.vmin = 16'($urandom_range(ev + 1, 65535));
        case (kind)
            RK_DRIFT: begin
                r.cur = 24'(cur);
                r.avg = 16'($urandom_range(EMPTY_AVG_MV, AVG_MAX_MV));
                if ($urandom_range(0, 3) != 0 && thr > 0)
                    r.vmax = 16'($urandom_range(0, thr - 1));
            end
            RK_FULL: begin
                r.cur = 24'(int'($urandom_range(0, 198)) - 99);
                r.avg = 16'($urandom_range(FULL_AVG_MV, AVG_MAX_MV));
                r.vmax = 16'($urandom_range(thr, 65535));
            end
            RK_EMPTY: begin
                r.cur = 24'(cur);
                if ($urandom_range(0, 1) != 0) begin
                    r.avg = 16'($urandom_range(AVG_MIN_MV, EMPTY_AVG_MV - 1));
                end else begin
                    r.avg = 16'($urandom_range(EMPTY_AVG_MV, AVG_MAX_MV));
                    r.vmin = 16'($urandom_range(0, ev));
                end
            end
            RK_BADV: begin
                r.cur = 24'(cur);
                r.avg = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, AVG_MIN_MV - 1))
                                                    : 16'($urandom_range(AVG_MAX_MV + 1, 65535));
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [39:0] got_v,
                                   input logic [39:0] want_v);
        $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got_v, want_v);
        error_count++;
    endtask

    // Sends one reading, predicts its result once accepted, then paces the sender.
    task automatic send_reading(input reading_t r);
        int gap;
        s_tdata <= r;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_soc.push_back(advance_soc(r));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 11);
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(31, 60) : $urandom_range(1, 30);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results(input int settle);
        s_tvalid <= 1'b0;
        while (pending_soc.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(input csoc_pkg::cfg_idx_t idx,
                             input logic [csoc_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            csoc_pkg::CFG_CAPACITY:  cap_mah = val[22:0];
            csoc_pkg::CFG_IDLE:      idle_ma = val[15:0];
            csoc_pkg::CFG_FULL_MV:   full_mv = val[15:0];
            csoc_pkg::CFG_EMPTY_MV:  empty_mv = val[15:0];
            csoc_pkg::CFG_HOLD:      hold_need = val[15:0];
            csoc_pkg::CFG_START_SOC: start_soc = val[9:0];
            csoc_pkg::CFG_START_CYC: start_cyc = val[15:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Settings change only once every predicted word has come back.
    task automatic apply_settings(input int cap, input int idle, input int fv, input int ev,
                                  input int hold);
        drain_results(SETTLE_CYCLES);
        write_reg(csoc_pkg::CFG_CAPACITY, csoc_pkg::CFG_DATA_W'(cap));
        write_reg(csoc_pkg::CFG_IDLE, csoc_pkg::CFG_DATA_W'(idle));
        write_reg(csoc_pkg::CFG_FULL_MV, csoc_pkg::CFG_DATA_W'(fv));
        write_reg(csoc_pkg::CFG_EMPTY_MV, csoc_pkg::CFG_DATA_W'(ev));
        write_reg(csoc_pkg::CFG_HOLD, csoc_pkg::CFG_DATA_W'(hold));
    endtask

    task automatic run_random(input int n_items);
        int            sent;
        int            run_len;
        int            pick;
        reading_kind_t kind;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                // A run of full readings, long enough to reach the hold count when that
                // is six or less, now and then broken by an ordinary reading.
                run_len = (hold_need <= 6) ? hold_need + 2 : $urandom_range(2, 8);
                repeat (run_len) begin
                    kind = ($urandom_range(0, 11) == 0) ? RK_DRIFT : RK_FULL;
                    send_reading(make_reading(kind));
                    sent++;
                end
            end else begin
                if (pick < 70) kind = RK_DRIFT;
                else if (pick < 80) kind = RK_EMPTY;
                else if (pick < 90) kind = RK_BADV;
                else kind = RK_NOISE;
                send_reading(make_reading(kind));
                sent++;
            end
        end
    endtask

    task automatic test_field_extremes();
        send_reading(pack_reading(0, 3700, 3300, 3400));
        send_reading(pack_reading(99, 3700, 3300, 3400));
        send_reading(pack_reading(100, 3700, 3300, 3400));
        send_reading(pack_reading(-100, 3700, 3300, 3400));
        send_reading(pack_reading(8388607, 3700, 3300, 3400));
        send_reading(pack_reading(-8388608, 3700, 3300, 3400));
        send_reading(pack_reading(0, 1999, 3300, 3400));
        send_reading(pack_reading(0, 5001, 3300, 3400));
        send_reading(pack_reading(0, 0, 0, 0));
        send_reading(pack_reading(0, 65535, 65535, 65535));
        send_reading(pack_reading(0, 5000, 65535, 3001));
        send_reading(pack_reading(0, 2000, 3300, 3400));
        send_reading(pack_reading(0, 3700, 3300, 3000));
        send_reading(pack_reading(-8388608, 3700, 3300, 3001));
    endtask

    task automatic test_full_empty_calibration();
        // Zero and all-ones voltages select the built-in defaults; a hold of
        // zero fires on the second full reading.
        apply_settings(CAP_DEF, IDLE_DEF, 0, UNSET_MV, 0);
        write_reg(csoc_pkg::CFG_START_SOC, csoc_pkg::CFG_DATA_W'(10'h3FF));
        write_reg(csoc_pkg::CFG_START_CYC, csoc_pkg::CFG_DATA_W'(16'hFFFF));
        send_reading(pack_reading(50, 3400, 3450, 3001));
        send_reading(pack_reading(-99, 3400, 3450, 3001));
        send_reading(pack_reading(0, 3400, 3450, 3001));
        send_reading(pack_reading(0, 3400, 3449, 3001));
        send_reading(pack_reading(0, 3400, 3450, 3001));
        send_reading(pack_reading(0, 3400, 3450, 2999));
        // A full voltage below the margin pushes the threshold near the top.
        apply_settings(CAP_DEF, IDLE_DEF, 40, 1, 2);
        repeat (4) send_reading(pack_reading(0, 4000, 65526, 2));
        send_reading(pack_reading(0, 4000, 65525, 2));
        send_reading(pack_reading(0, 4000, 65535, 1));
    endtask

    task automatic test_random_defaults();
        apply_settings(CAP_DEF, IDLE_DEF, FULL_MV_DEF_R, EMPTY_MV_DEF_R, HOLD_DEF);
        run_random(220);
    endtask

    task automatic test_settings_extremes();
        apply_settings(1, 0, 0, UNSET_MV, 0);
        run_random(200);
        apply_settings(23'h7FFFFF, 65535, 40, 1, 65535);
        run_random(150);
        // Zero capacity turns integration off altogether.
        apply_settings(0, 100, UNSET_MV, 0, 1);
        run_random(100);
    endtask

    task automatic test_random_settings();
        int cap;
        repeat (6) begin
            cap = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 400)
                                              : $urandom_range(400, 200000);
            apply_settings(cap, $urandom_range(0, 300), $urandom_range(3400, 4300),
                           $urandom_range(2600, 3400), $urandom_range(0, 5));
            run_random(200);
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr <= csoc_pkg::CFG_CAPACITY;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cap_mah = 23'(CAP_DEF);
        idle_ma = 16'(IDLE_DEF);
        full_mv = 16'(FULL_MV_DEF_R);
        empty_mv = 16'(EMPTY_MV_DEF_R);
        hold_need = 16'(HOLD_DEF);
        start_soc = 10'(START_SOC_DEF);
        start_cyc = 16'(START_CYC_DEF);
        soc_now = (start_soc > SOC_FULL) ? 10'(SOC_FULL) : start_soc;
        charge_rem = 0;
        full_seen = 1'b0;
        hold_cnt = '0;
        cycle_cnt = start_cyc;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_field_extremes();
        test_full_empty_calibration();
        test_random_defaults();
        test_settings_extremes();
        test_random_settings();
        drain_results(END_CYCLES);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Receiver back-pressure: stretches of different stall patterns.
    initial begin : receiver_stalls
        stall_mode_t mode;
        int          span;
        int          period;
        int          k;
        m_tready <= 1'b0;
        forever begin
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(60, 400);
            period = $urandom_range(2, 6);
            for (k = 0; k < span; k++) begin
                @(posedge aclk);
                case (mode)
                    RX_OPEN:     m_tready <= 1'b1;
                    RX_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: m_tready <= (k % period == 0);
                    default:     m_tready <= (k % 40 == 39);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : check_words
        soc_result_t got;
        soc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_soc.size() == 0) begin
                report_mismatch("result word with no prediction", m_tdata, '0);
            end else begin
                want = pending_soc.pop_front();
                if (got.soc !== want.soc)
                    report_mismatch("soc_tenth_pct", got.soc, want.soc);
                if (got.pct !== want.pct)
                    report_mismatch("soc_whole_pct", got.pct, want.pct);
                if (got.cycles !== want.cycles)
                    report_mismatch("cycle_count", got.cycles, want.cycles);
                if (got.full_ev !== want.full_ev)
                    report_mismatch("full_event", got.full_ev, want.full_ev);
                if (got.empty_ev !== want.empty_ev)
                    report_mismatch("empty_event", got.empty_ev, want.empty_ev);
                if (got.pad !== want.pad)
                    report_mismatch("padding bits", got.pad, want.pad);
            end
        end
    end

    always @(posedge aclk) begin
        elapsed_cycles++;
        if (elapsed_cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/csoc_pkg.sv
hdl/csoc_ctrl.sv
hdl/csoc_dp.sv
hdl/coulomb_soc_tracker.sv
test/tb_coulomb_soc_tracker.sv
